[rtl/core/gppc_pkg.sv]
// Package for the goal packet polar converter: types, constants and the
// CORDIC arctangent table. Used by every module in rtl/core.
package gppc_pkg;

  localparam int unsigned CordicIters = 31;
  localparam int unsigned CoordW      = 40;  // signed CORDIC coordinate width
  localparam int unsigned IterW       = 5;
  localparam int unsigned SqrtW       = 32;
  localparam int unsigned SqrtSteps   = 16;
  localparam int unsigned OutW        = 13;

  localparam logic [8:0]  OffsetSub   = 9'd60;
  localparam logic [31:0] RightAngle  = 32'h4000_0000;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;
  localparam logic [12:0] StepsPerTurn = 13'd5760;
  localparam logic [12:0] OriginAngle = 13'd1440;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SECOND  = 3'd1,
    PH_PAY0    = 3'd2,
    PH_PAY1    = 3'd3,
    PH_PAY2    = 3'd4,
    PH_PAY3    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ITER,
    ST_FINISH,
    ST_OUT
  } state_t;

  localparam logic [1:0] CFG_ATTACK_BLUE = 2'd0;
  localparam logic [1:0] CFG_START_FIRST = 2'd1;
  localparam logic [1:0] CFG_START_SECOND = 2'd2;

  typedef struct packed {
    logic load;     // latch goal coordinates and prime both units
    logic iterate;  // run one CORDIC step and, while the trial bit lasts, one square root step
    logic finish;   // form the final angles and magnitudes
  } cmd_t;

  typedef struct packed {
    logic last_iter;
  } status_t;

  function automatic logic [31:0] atan_tab(input logic [IterW-1:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0:  t = 32'h20000000; 5'd1:  t = 32'h12E4051E; 5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4; 5'd4:  t = 32'h028B0D43; 5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E; 5'd7:  t = 32'h00517C55; 5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F; 5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518; 5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146; 5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005; 5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

[rtl/core/gppc_polar.sv]
// One goal's polar unit: an iterative CORDIC vectoring engine and a
// digit-by-digit square root that step together. Depends on gppc_pkg.
module gppc_polar import gppc_pkg::*; (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 iterate,
  input  logic                 finish,
  input  logic [IterW-1:0]     iter,
  input  logic signed [8:0]    gx,
  input  logic signed [8:0]    gy,
  output logic [OutW-1:0]      angle,
  output logic [OutW-1:0]      distance
);

  logic signed [CoordW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [31:0]              z_r, z_nxt;
  logic                     origin_r, origin_nxt;
  logic [SqrtW-1:0]         n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [OutW-1:0]          angle_r, angle_nxt, dist_r, dist_nxt;

  logic signed [CoordW-1:0] sx, sy, dx, dy;
  logic signed [17:0]       sq;
  logic [31:0]              brg;
  logic [44:0]              prod;
  logic [12:0]              rnd;
  logic [SqrtW-1:0]         trial;

  always_comb begin
    cx_nxt = cx_r; cy_nxt = cy_r; z_nxt = z_r; origin_nxt = origin_r;
    n_nxt = n_r; res_nxt = res_r; bit_nxt = bit_r;
    angle_nxt = angle_r; dist_nxt = dist_r;
    sx = {{(CoordW-33){gx[8]}}, gx, 24'd0};
    sy = {{(CoordW-33){gy[8]}}, gy, 24'd0};
    dx = cy_r >>> iter;
    dy = cx_r >>> iter;
    sq = 18'(gx * gx) + 18'(gy * gy);
    trial = res_r + bit_r;
    brg = RightAngle - z_r;
    prod = {13'd0, brg} * 45'(StepsPerTurn);
    rnd = 13'((prod + 45'(HalfTurn)) >> 32);
    if (load) begin
      origin_nxt = (gx == 9'sd0) && (gy == 9'sd0);
      if (gx < 0) begin
        cx_nxt = -sx; cy_nxt = -sy; z_nxt = HalfTurn;
      end else begin
        cx_nxt = sx; cy_nxt = sy; z_nxt = 32'd0;
      end
      n_nxt = {4'd0, sq[17:0], 10'd0};
      res_nxt = '0;
      bit_nxt = 32'h4000_0000;
    end else if (iterate) begin
      if (cy_r >= 0) begin
        cx_nxt = cx_r + dx; cy_nxt = cy_r - dy; z_nxt = z_r + atan_tab(iter);
      end else begin
        cx_nxt = cx_r - dx; cy_nxt = cy_r + dy; z_nxt = z_r - atan_tab(iter);
      end
      // Square root steps stop once the trial bit has shifted out.
      if (bit_r != '0) begin
        if (n_r >= trial) begin
          n_nxt = n_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end
    end else if (finish) begin
      if (origin_r) angle_nxt = OriginAngle;
      else if (rnd >= StepsPerTurn) angle_nxt = '0;
      else angle_nxt = rnd;
      dist_nxt = 13'((res_r + 32'd1) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt; cy_r <= cy_nxt; z_r <= z_nxt; origin_r <= origin_nxt;
    n_r <= n_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
    angle_r <= angle_nxt; dist_r <= dist_nxt;
  end

  assign angle    = angle_r;
  assign distance = dist_r;

endmodule

[rtl/core/gppc_datapath.sv]
// Datapath: packet parser, payload registers, goal offset and selection and
// the two polar units. Depends on gppc_pkg and gppc_polar.
module gppc_datapath import gppc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_take,
  input  logic [7:0]        rx_byte,
  input  logic              attack_blue,
  input  logic [7:0]        start_first,
  input  logic [7:0]        start_second,
  input  cmd_t              cmd,
  output status_t           status,
  output logic              pkt_done,
  output logic [OutW-1:0]   attack_angle,
  output logic [OutW-1:0]   attack_distance,
  output logic [OutW-1:0]   defend_angle,
  output logic [OutW-1:0]   defend_distance,
  output logic              attack_visible,
  output logic              defend_visible,
  output logic signed [8:0] attack_goal_x
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] pay_r [3];
  logic [7:0] last_r;
  logic [IterW-1:0] iter_r;
  logic signed [8:0] yx, yy, bx, by, ax, ay, ddx, ddy;
  logic signed [8:0] ax_r, ay_r, dx_r, dy_r;

  always_comb begin
    phase_nxt = phase_r;
    pkt_done = 1'b0;
    if (byte_take) begin
      unique case (phase_r)
        PH_SECOND: begin
          if (rx_byte == start_second) phase_nxt = PH_PAY0;
          else if (rx_byte == start_first) phase_nxt = PH_SECOND;
          else phase_nxt = PH_HUNT;
        end
        PH_PAY0: phase_nxt = PH_PAY1;
        PH_PAY1: phase_nxt = PH_PAY2;
        PH_PAY2: phase_nxt = PH_PAY3;
        PH_PAY3: begin
          phase_nxt = PH_HUNT;
          pkt_done = 1'b1;
        end
        default: phase_nxt = (rx_byte == start_first) ? PH_SECOND : PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= PH_HUNT;
    else phase_r <= phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      if (phase_r == PH_PAY0) pay_r[0] <= rx_byte;
      if (phase_r == PH_PAY1) pay_r[1] <= rx_byte;
      if (phase_r == PH_PAY2) pay_r[2] <= rx_byte;
      if (phase_r == PH_PAY3) last_r <= rx_byte;
    end
  end

  always_comb begin
    yx = (pay_r[0] != 8'd0) ? $signed({1'b0, pay_r[0]}) - $signed(OffsetSub)
                            : $signed({1'b0, pay_r[0]});
    yy = (pay_r[0] != 8'd0) ? $signed({1'b0, pay_r[1]}) - $signed(OffsetSub)
                            : $signed({1'b0, pay_r[1]});
    bx = (pay_r[2] != 8'd0) ? $signed({1'b0, pay_r[2]}) - $signed(OffsetSub)
                            : $signed({1'b0, pay_r[2]});
    by = (pay_r[2] != 8'd0) ? $signed({1'b0, last_r}) - $signed(OffsetSub)
                            : $signed({1'b0, last_r});
    ax  = attack_blue ? bx : yx;
    ay  = attack_blue ? by : yy;
    ddx = attack_blue ? yx : bx;
    ddy = attack_blue ? yy : by;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= ax; ay_r <= ay; dx_r <= ddx; dy_r <= ddy;
    end
    if (cmd.load) iter_r <= '0;
    else if (cmd.iterate) iter_r <= iter_r + 1'b1;
  end

  assign status.last_iter = (iter_r == IterW'(CordicIters - 1));

  gppc_polar u_attack (
    .clk(clk), .load(cmd.load), .iterate(cmd.iterate), .finish(cmd.finish),
    .iter(iter_r), .gx(ax), .gy(ay),
    .angle(attack_angle), .distance(attack_distance)
  );

  gppc_polar u_defend (
    .clk(clk), .load(cmd.load), .iterate(cmd.iterate), .finish(cmd.finish),
    .iter(iter_r), .gx(ddx), .gy(ddy),
    .angle(defend_angle), .distance(defend_distance)
  );

  assign attack_visible = (ay_r != 9'sd0);
  assign defend_visible = (dy_r != 9'sd0);
  assign attack_goal_x  = ax_r;

endmodule

[rtl/core/gppc_ctrl.sv]
// Controller state machine: takes bytes, sequences the polar units and holds
// the result word until it is taken. Depends on gppc_pkg.
module gppc_ctrl import gppc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    pkt_done,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && pkt_done) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        cmd.iterate = 1'b1;
        if (status.last_iter) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/goal_packet_polar_converter_unit.sv]
// Goal packet polar converter top level: configuration registers, controller
// and datapath. Depends on gppc_pkg, gppc_ctrl and gppc_datapath.
//
// Bytes that do not complete a packet are taken while the controller is idle
// and give no word. The byte that completes a packet starts both goals'
// conversion: a load step, 31 CORDIC iterations shared by both units (the
// square root steps with them until its trial bit has shifted out), a finish
// step and an output state that holds the result word until it is taken.
// The next byte is accepted only after the word has been taken; the CordicIters
// count of the CORDIC loop sets how long the conversion runs.
module goal_packet_polar_converter_unit import gppc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [12:0]       out_attack_angle,
  output logic [12:0]       out_attack_distance,
  output logic [12:0]       out_defend_angle,
  output logic [12:0]       out_defend_distance,
  output logic              out_attack_visible,
  output logic              out_defend_visible,
  output logic signed [8:0] out_attack_goal_x,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);

  logic       attack_blue_r;
  logic [7:0] start_first_r, start_second_r;
  cmd_t       cmd;
  status_t    status;
  logic       pkt_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_blue_r <= 1'b0;
      start_first_r <= '0;
      start_second_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ATTACK_BLUE) attack_blue_r <= cfg_wdata[0];
      if (cfg_index == CFG_START_FIRST) start_first_r <= cfg_wdata;
      if (cfg_index == CFG_START_SECOND) start_second_r <= cfg_wdata;
    end
  end

  gppc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .pkt_done(pkt_done),
    .status(status), .cmd(cmd)
  );

  gppc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .byte_take(in_valid && in_ready),
    .rx_byte(in_rx_byte), .attack_blue(attack_blue_r),
    .start_first(start_first_r), .start_second(start_second_r),
    .cmd(cmd), .status(status), .pkt_done(pkt_done),
    .attack_angle(out_attack_angle), .attack_distance(out_attack_distance),
    .defend_angle(out_defend_angle), .defend_distance(out_defend_distance),
    .attack_visible(out_attack_visible), .defend_visible(out_defend_visible),
    .attack_goal_x(out_attack_goal_x)
  );

  // Input and output sides never handshake in the same cycle.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in_ready with out_valid");

  // A result word appears only after a finish command.
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish)) else $error("word without finish");

  a_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_attack_angle < StepsPerTurn && out_defend_angle < StepsPerTurn))
    else $error("angle out of range");

endmodule
